// ----- hdl/dmmp_pkg.sv -----
// ----------------------------------------------------------------------------
// dmmp_pkg
// Shared types and codes for the depth min/max pyramid block.
// ----------------------------------------------------------------------------
package dmmp_pkg;

  // largest finite single, used as the empty depth code
  localparam logic [30:0] DEPTH_MAX_CODE = 31'h7F7F_FFFF;

  // width used for coordinate against dimension compares
  localparam int CMP_W = 16;

  // item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DONE    = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  // configuration register indexes
  localparam logic REG_BASE_WIDTH  = 1'b0;
  localparam logic REG_BASE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_BLD_RUN,
    ST_BLD_DONE,
    ST_CLEAR
  } dmmp_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_go;
    logic read_go;
    logic bld_init;
    logic bld_step;
    logic clr_step;
    logic res_read;
    logic res_done;
  } dmmp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_start;
    logic clr_last;
    logic bld_none;
    logic bld_last;
  } dmmp_status_t;

endpackage

// ----- hdl/depth_min_max_pyramid.sv -----
// ----------------------------------------------------------------------------
// depth_min_max_pyramid
// Hierarchical min/max depth pyramid built from a loaded base depth level.
//
// channel  | handshake                   | payload
// ---------+-----------------------------+----------------------------------
// item     | start_i / busy_o            | mode_i level_i x_i y_i depth_i
// result   | res_valid_o (strobe)        | max_depth_o min_depth_o status_o
// config   | cfg_valid_i / cfg_ready_o   | cfg_index_i cfg_data_i
//
// A load writes the base store when in range; a read is a registered store
// read, then the result strobe. A build visits every texel of every upper level
// (four parent reads through the single read port of each store, then the
// write) and ends with the done strobe. A size change starts a clearing
// pass over every store entry (65536 base entries at the default size),
// during which busy_o is high. Reset leaves the pyramid empty. The
// receiver cannot stall: each result is on the ports for one cycle.
// ----------------------------------------------------------------------------
module depth_min_max_pyramid import dmmp_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  level_i,
  input  logic [7:0]  x_i,
  input  logic [7:0]  y_i,
  input  logic [30:0] depth_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  output logic        res_valid_o,
  output logic [30:0] max_depth_o,
  output logic [30:0] min_depth_o,
  output logic [1:0]  status_o
);

  dmmp_cmd_t    cmd;
  dmmp_status_t status;

  // controller
  dmmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .mode_i      (mode_i),
    .busy_o      (busy_o),
    .cfg_ready_o (cfg_ready_o),
    .res_valid_o (res_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath and stores
  dmmp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .level_i      (level_i),
    .x_i          (x_i),
    .y_i          (y_i),
    .depth_i      (depth_i),
    .max_depth_o  (max_depth_o),
    .min_depth_o  (min_depth_o),
    .status_res_o (status_o)
  );

endmodule

// ----- hdl/dmmp_ram.sv -----
// ----------------------------------------------------------------------------
// dmmp_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmmp_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dmmp_datapath.sv -----
// ----------------------------------------------------------------------------
// dmmp_datapath
// Size registers, level address tables, depth stores, build walker and
// clearing counter of the depth pyramid.
// ----------------------------------------------------------------------------
module dmmp_datapath import dmmp_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dmmp_cmd_t    cmd_i,
  output dmmp_status_t status_o,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [8:0]   cfg_data_i,
  input  logic [3:0]   level_i,
  input  logic [7:0]   x_i,
  input  logic [7:0]   y_i,
  input  logic [30:0]  depth_i,
  output logic [30:0]  max_depth_o,
  output logic [30:0]  min_depth_o,
  output logic [1:0]   status_res_o
);

  // level layout helpers, evaluated at elaboration
  function automatic int cap_w_lg(int k);
    return $clog2(((MAX_WIDTH - 1) >> k) + 1);
  endfunction

  function automatic int cap_h(int k);
    return ((MAX_HEIGHT - 1) >> k) + 1;
  endfunction

  function automatic int lvl_off(int l);
    int s;
    s = 0;
    for (int k = 1; k < 16; k++) begin
      if (k < l) s = s + (cap_h(k) << cap_w_lg(k));
    end
    return s;
  endfunction

  localparam int XWR        = $clog2(MAX_WIDTH);
  localparam int YWR        = $clog2(MAX_HEIGHT);
  localparam int XW         = (XWR > 0) ? XWR : 1;
  localparam int YW         = (YWR > 0) ? YWR : 1;
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int NL         = ((XWR > YWR) ? XWR : YWR) + 1;
  localparam int BASE_DEPTH = (1 << XW) * MAX_HEIGHT;
  localparam int PYR_RAW    = lvl_off(NL);
  localparam int PYR_DEPTH  = (PYR_RAW > 1) ? PYR_RAW : 1;
  localparam int CLR_DEPTH  = (BASE_DEPTH > PYR_DEPTH) ? BASE_DEPTH : PYR_DEPTH;
  localparam int BAW        = $clog2(BASE_DEPTH);
  localparam int PAW        = (PYR_DEPTH > 1) ? $clog2(PYR_DEPTH) : 1;
  localparam int CLW        = $clog2(CLR_DEPTH);

  // constant per level tables
  logic [PAW-1:0] off_tab [16];
  logic [3:0]     lw_tab  [16];

  for (genvar g = 0; g < 16; g++) begin : g_tab
    assign off_tab[g] = PAW'(lvl_off(g));
    assign lw_tab[g]  = 4'(cap_w_lg(g));
  end

  // size registers
  logic [8:0]    base_width_q, base_width_d;
  logic [8:0]    base_height_q, base_height_d;
  logic [WW-1:0] cur_w_q, cur_w_d;
  logic [HW-1:0] cur_h_q, cur_h_d;
  logic          nonempty_q, nonempty_d;
  logic [8:0]    raw_w, raw_h;
  logic [WW-1:0] sat_w;
  logic [HW-1:0] sat_h;
  logic          fill_start;

  // resize on register write
  always_comb begin
    base_width_d  = base_width_q;
    base_height_d = base_height_q;
    cur_w_d       = cur_w_q;
    cur_h_d       = cur_h_q;
    nonempty_d    = nonempty_q;
    fill_start    = 1'b0;
    raw_w = (cfg_index_i == REG_BASE_WIDTH) ? cfg_data_i : base_width_q;
    raw_h = (cfg_index_i == REG_BASE_HEIGHT) ? cfg_data_i : base_height_q;
    sat_w = (32'(raw_w) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(raw_w);
    sat_h = (32'(raw_h) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(raw_h);
    if (cfg_we_i) begin
      base_width_d  = raw_w;
      base_height_d = raw_h;
      if (raw_w == 9'd0 || raw_h == 9'd0) begin
        nonempty_d = 1'b0;
      end else if (!(nonempty_q && sat_w == cur_w_q && sat_h == cur_h_q)) begin
        cur_w_d    = sat_w;
        cur_h_d    = sat_h;
        nonempty_d = 1'b1;
        fill_start = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_width_q  <= '0;
      base_height_q <= '0;
      cur_w_q       <= '0;
      cur_h_q       <= '0;
      nonempty_q    <= 1'b0;
    end else begin
      base_width_q  <= base_width_d;
      base_height_q <= base_height_d;
      cur_w_q       <= cur_w_d;
      cur_h_q       <= cur_h_d;
      nonempty_q    <= nonempty_d;
    end
  end

  // clearing counter
  logic [CLW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (fill_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // item side decode: load range and read range checks
  logic           load_in;
  logic           lvl_ok;
  logic           rd_ok;
  logic [BAW-1:0] item_baddr;
  logic [PAW-1:0] item_paddr;
  logic [3:0]     lvl_m1;

  always_comb begin
    lvl_m1  = level_i - 4'd1;
    load_in = nonempty_q && (CMP_W'(x_i) < CMP_W'(cur_w_q)) &&
              (CMP_W'(y_i) < CMP_W'(cur_h_q));
    lvl_ok  = (level_i == 4'd0) || (((cur_w_q - 1'b1) >> lvl_m1) != '0) ||
              (((cur_h_q - 1'b1) >> lvl_m1) != '0);
    rd_ok   = nonempty_q && lvl_ok &&
              (CMP_W'(x_i) <= CMP_W'((cur_w_q - 1'b1) >> level_i)) &&
              (CMP_W'(y_i) <= CMP_W'((cur_h_q - 1'b1) >> level_i));
    item_baddr = BAW'((32'(y_i) << XW) + 32'(x_i));
    item_paddr = PAW'(32'(off_tab[level_i]) + (32'(y_i) << lw_tab[level_i]) + 32'(x_i));
  end

  // read transaction flags
  logic rd_ok_q, rd_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q   <= 1'b0;
      rd_base_q <= 1'b0;
    end else if (cmd_i.read_go) begin
      rd_ok_q   <= rd_ok;
      rd_base_q <= (level_i == 4'd0);
    end
  end

  // build walker registers
  logic [3:0]    lvl_q;
  logic [WW-1:0] pw_q;
  logic [HW-1:0] ph_q;
  logic [XW-1:0] cx_q;
  logic [YW-1:0] cy_q;
  logic [2:0]    phase_q;
  logic [30:0]   acc_max_q, acc_min_q;

  logic [WW-1:0] cw;
  logic [HW-1:0] ch;
  logic [31:0]   px, py;
  logic          x_end, y_end, lvl_end;
  logic [BAW-1:0] bld_baddr;
  logic [PAW-1:0] bld_paddr, bld_waddr;
  logic [3:0]    plvl;
  logic [30:0]   base_rd, max_rd, min_rd;
  logic [30:0]   par_max, par_min, new_max, new_min;
  logic          bld_we;

  // parent corner addresses and child combine
  always_comb begin
    cw      = WW'((32'(pw_q) + 1) >> 1);
    ch      = HW'((32'(ph_q) + 1) >> 1);
    plvl    = lvl_q - 4'd1;
    px      = (32'(cx_q) << 1);
    py      = (32'(cy_q) << 1);
    if (phase_q[0] && (px + 1 < 32'(pw_q))) px = px + 1;
    if (phase_q[1] && (py + 1 < 32'(ph_q))) py = py + 1;
    bld_baddr = BAW'((py << XW) + px);
    bld_paddr = PAW'(32'(off_tab[plvl]) + (py << lw_tab[plvl]) + px);
    bld_waddr = PAW'(32'(off_tab[lvl_q]) + (32'(cy_q) << lw_tab[lvl_q]) + 32'(cx_q));
    x_end   = (32'(cx_q) + 1 == 32'(cw));
    y_end   = (32'(cy_q) + 1 == 32'(ch));
    lvl_end = (cw == WW'(1)) && (ch == HW'(1));
    par_max = (lvl_q == 4'd1) ? base_rd : max_rd;
    par_min = (lvl_q == 4'd1) ? base_rd : min_rd;
    if (phase_q == 3'd1) begin
      new_max = par_max;
      new_min = par_min;
    end else begin
      new_max = (par_max > acc_max_q) ? par_max : acc_max_q;
      new_min = (par_min < acc_min_q) ? par_min : acc_min_q;
    end
    bld_we  = cmd_i.bld_step && (phase_q == 3'd4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q   <= '0;
      pw_q    <= '0;
      ph_q    <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      phase_q <= '0;
    end else if (cmd_i.bld_init) begin
      lvl_q   <= 4'd1;
      pw_q    <= cur_w_q;
      ph_q    <= cur_h_q;
      cx_q    <= '0;
      cy_q    <= '0;
      phase_q <= '0;
    end else if (cmd_i.bld_step) begin
      if (phase_q == 3'd4) begin
        phase_q <= '0;
        if (x_end) begin
          cx_q <= '0;
          if (y_end) begin
            cy_q  <= '0;
            pw_q  <= cw;
            ph_q  <= ch;
            lvl_q <= lvl_q + 4'd1;
          end else begin
            cy_q <= cy_q + 1'b1;
          end
        end else begin
          cx_q <= cx_q + 1'b1;
        end
      end else begin
        phase_q <= phase_q + 3'd1;
      end
    end
  end

  // running min and max over the four parents
  always_ff @(posedge clk_i) begin
    if (cmd_i.bld_step && phase_q != 3'd0) begin
      acc_max_q <= new_max;
      acc_min_q <= new_min;
    end
  end

  // store ports
  logic           base_we, pyr_we;
  logic [BAW-1:0] base_waddr, base_raddr;
  logic [30:0]    base_wdata, max_wdata, min_wdata;
  logic [PAW-1:0] pyr_waddr, pyr_raddr;

  always_comb begin
    base_we    = cmd_i.clr_step ? (32'(clr_q) < BASE_DEPTH) : (cmd_i.load_go && load_in);
    base_waddr = cmd_i.clr_step ? BAW'(clr_q) : item_baddr;
    base_wdata = cmd_i.clr_step ? DEPTH_MAX_CODE : depth_i;
    base_raddr = cmd_i.bld_step ? bld_baddr : item_baddr;
    pyr_we     = cmd_i.clr_step ? (32'(clr_q) < PYR_DEPTH) : bld_we;
    pyr_waddr  = cmd_i.clr_step ? PAW'(clr_q) : bld_waddr;
    max_wdata  = cmd_i.clr_step ? DEPTH_MAX_CODE : new_max;
    min_wdata  = cmd_i.clr_step ? DEPTH_MAX_CODE : new_min;
    pyr_raddr  = cmd_i.bld_step ? bld_paddr : item_paddr;
  end

  dmmp_ram #(.WIDTH(31), .DEPTH(BASE_DEPTH), .AW(BAW)) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (base_waddr),
    .wdata_i (base_wdata),
    .raddr_i (base_raddr),
    .rdata_o (base_rd)
  );

  dmmp_ram #(.WIDTH(31), .DEPTH(PYR_DEPTH), .AW(PAW)) u_max_ram (
    .clk_i   (clk_i),
    .we_i    (pyr_we),
    .waddr_i (pyr_waddr),
    .wdata_i (max_wdata),
    .raddr_i (pyr_raddr),
    .rdata_o (max_rd)
  );

  dmmp_ram #(.WIDTH(31), .DEPTH(PYR_DEPTH), .AW(PAW)) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (pyr_we),
    .waddr_i (pyr_waddr),
    .wdata_i (min_wdata),
    .raddr_i (pyr_raddr),
    .rdata_o (min_rd)
  );

  // status to the controller
  always_comb begin
    status_o.fill_start = fill_start;
    status_o.clr_last   = (32'(clr_q) == CLR_DEPTH - 1);
    status_o.bld_none   = !nonempty_q || (cur_w_q == WW'(1) && cur_h_q == HW'(1));
    status_o.bld_last   = (phase_q == 3'd4) && x_end && y_end && lvl_end;
  end

  // result fields
  always_comb begin
    max_depth_o  = '0;
    min_depth_o  = '0;
    status_res_o = STATUS_OK;
    if (cmd_i.res_done) begin
      status_res_o = STATUS_DONE;
    end else if (cmd_i.res_read) begin
      if (rd_ok_q) begin
        max_depth_o = rd_base_q ? base_rd : max_rd;
        min_depth_o = rd_base_q ? base_rd : min_rd;
      end else begin
        status_res_o = STATUS_REFUSED;
      end
    end
  end

endmodule

// ----- hdl/dmmp_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmmp_ctrl
// Controller of the depth pyramid: item dispatch, build walk, clearing pass.
// ----------------------------------------------------------------------------
module dmmp_ctrl import dmmp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [1:0]   mode_i,
  output logic         busy_o,
  output logic         cfg_ready_o,
  output logic         res_valid_o,
  input  dmmp_status_t status_i,
  output dmmp_cmd_t    cmd_o
);

  dmmp_state_e state_q, state_d;
  logic        accept;

  assign accept = start_i && (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (status_i.fill_start) begin
          state_d = ST_CLEAR;
        end else if (accept && mode_i == MODE_READ) begin
          state_d = ST_RD_OUT;
        end else if (accept && mode_i == MODE_BUILD) begin
          state_d = status_i.bld_none ? ST_BLD_DONE : ST_BLD_RUN;
        end
      end
      ST_RD_OUT:   state_d = ST_IDLE;
      ST_BLD_RUN:  if (status_i.bld_last) state_d = ST_BLD_DONE;
      ST_BLD_DONE: state_d = ST_IDLE;
      ST_CLEAR: begin
        if (!status_i.fill_start && status_i.clr_last) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    busy_o      = (state_q != ST_IDLE);
    cfg_ready_o = (state_q == ST_IDLE && !start_i) || (state_q == ST_CLEAR);
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_go  = accept && (mode_i == MODE_LOAD);
        cmd_o.read_go  = accept && (mode_i == MODE_READ);
        cmd_o.bld_init = accept && (mode_i == MODE_BUILD);
      end
      ST_RD_OUT: begin
        cmd_o.res_read = 1'b1;
        res_valid_o    = 1'b1;
      end
      ST_BLD_RUN:  cmd_o.bld_step = 1'b1;
      ST_BLD_DONE: begin
        cmd_o.res_done = 1'b1;
        res_valid_o    = 1'b1;
      end
      ST_CLEAR:    cmd_o.clr_step = 1'b1;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // results are single cycle strobes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for two cycles");

  // leaving idle needs an accepted transaction or a resize
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> ($past(start_i) || $past(status_i.fill_start)))
    else $error("busy without a cause");

  // a configuration write never coincides with an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !(start_i && !busy_o))
    else $error("configuration ready while an item is accepted");

  // clearing pass never drives a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_step |-> !res_valid_o)
    else $error("result during clearing pass");

endmodule
